[hw/rtl/cfe_pkg.sv]
// Package for the CRC framed packet encoder: codes, command and config types,
// the CRC-16/CCITT-FALSE byte update and sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package cfe_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam logic [15:0] MaxBody    = 16'd256;
   localparam logic [15:0] CrcInit    = 16'hFFFF;
   localparam logic [15:0] CrcPoly    = 16'h1021;
   localparam logic [3:0]  HeaderLen  = 4'd8;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TOO_LONG = 2'd1,
      STATUS_NO_FRAME = 2'd2,
      STATUS_IN_FRAME = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_MAGIC_FIRST  = 2'd0,
      CSR_MAGIC_SECOND = 2'd1,
      CSR_VERSION      = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_ERROR  = 2'd0,
      CMD_HEADER = 2'd1,
      CMD_BODY   = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      status_type   status;
      logic [7:0]   frame_type;
      logic [15:0]  sequence_number;
      logic [15:0]  body_length;
      logic [7:0]   body_byte;
      logic         has_crc;
   } cmd_type;

   typedef struct packed {
      logic [7:0] magic_first;
      logic [7:0] magic_second;
      logic [7:0] version_byte;
   } cfg_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[hw/rtl/cfe_req_if.sv]
// Request channel interface of the framed packet encoder.
// Depends on nothing.
`timescale 1ns / 1ps

interface cfe_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [7:0]  frame_type;
   logic [15:0] sequence_number;
   logic [15:0] body_length;
   logic [7:0]  body_byte;

   modport source (output valid, func, frame_type, sequence_number, body_length, body_byte,
                   input ready);
   modport sink (input valid, func, frame_type, sequence_number, body_length, body_byte,
                 output ready);
endinterface

[hw/rtl/cfe_rsp_if.sv]
// Response channel interface of the framed packet encoder.
// Depends on nothing.
`timescale 1ns / 1ps

interface cfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       frame_end;
   logic [1:0] status;

   modport source (output valid, out_byte, run_last, frame_end, status, input ready);
   modport sink (input valid, out_byte, run_last, frame_end, status, output ready);
endinterface

[hw/rtl/cfe_front.sv]
// Front end: accepts request transactions, tracks the open frame and turns
// each transaction into one command. Depends on cfe_pkg and cfe_req_if.
`timescale 1ns / 1ps

module cfe_front (
   input  logic             clock,
   input  logic             reset,
   cfe_req_if.sink          req_bus,
   input  logic             queue_full,
   output logic             cmd_push,
   output cfe_pkg::cmd_type cmd_data
);
   import cfe_pkg::*;

   logic        frame_open_ff, frame_open_in;
   logic [15:0] remain_ff, remain_in;
   logic        accept;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && !queue_full;
   assign cmd_push      = accept;

   always_comb begin
      frame_open_in            = frame_open_ff;
      remain_in                = remain_ff;
      cmd_data.kind            = CMD_ERROR;
      cmd_data.status          = STATUS_OK;
      cmd_data.frame_type      = req_bus.frame_type;
      cmd_data.sequence_number = req_bus.sequence_number;
      cmd_data.body_length     = req_bus.body_length;
      cmd_data.body_byte       = req_bus.body_byte;
      cmd_data.has_crc         = 1'b0;
      if (!req_bus.func) begin
         if (frame_open_ff) begin
            cmd_data.status = STATUS_IN_FRAME;
         end else if (req_bus.body_length > MaxBody) begin
            cmd_data.status = STATUS_TOO_LONG;
         end else begin
            cmd_data.kind    = CMD_HEADER;
            cmd_data.has_crc = (req_bus.body_length == 16'd0);
            if (accept && req_bus.body_length != 16'd0) begin
               frame_open_in = 1'b1;
               remain_in     = req_bus.body_length;
            end
         end
      end else begin
         if (!frame_open_ff) begin
            cmd_data.status = STATUS_NO_FRAME;
         end else begin
            cmd_data.kind    = CMD_BODY;
            cmd_data.has_crc = (remain_ff == 16'd1);
            if (accept) begin
               remain_in = remain_ff - 16'd1;
               if (remain_ff == 16'd1) begin
                  frame_open_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         remain_ff     <= 16'd0;
      end else begin
         frame_open_ff <= frame_open_in;
         remain_ff     <= remain_in;
      end
   end

   a_open_matches_count: assert property (@(posedge clock) disable iff (reset)
      frame_open_ff == (remain_ff != 16'd0))
      else $error("frame open flag disagrees with remaining count");

endmodule

[hw/rtl/cfe_queue.sv]
// Small command queue between front and back end.
// Depends on cfe_pkg.
`timescale 1ns / 1ps

module cfe_queue #(
   parameter int unsigned DEPTH = cfe_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cfe_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output cfe_pkg::cmd_type head_data
);
   import cfe_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   cmd_type         entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == FullCnt);
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

[hw/rtl/cfe_back.sv]
// Back end: expands each command into frame bytes, keeps the running CRC
// and holds the response register. Depends on cfe_pkg and cfe_rsp_if.
`timescale 1ns / 1ps

module cfe_back (
   input  logic             clock,
   input  logic             reset,
   input  cfe_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   input  cfe_pkg::cmd_type cmd,
   output logic             cmd_pop,
   cfe_rsp_if.source        rsp_bus
);
   import cfe_pkg::*;

   logic [3:0]  step_ff, step_in;
   logic [15:0] crc_ff, crc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff;
   logic        run_last_ff;
   logic        frame_end_ff;
   status_type  status_ff;

   logic [3:0]  n_data;
   logic [3:0]  last_step;
   logic        emit;
   logic        is_last;
   logic        hash;
   logic [7:0]  cur_byte;

   always_comb begin
      n_data    = (cmd.kind == CMD_HEADER) ? HeaderLen : 4'd1;
      last_step = cmd.has_crc ? n_data + 4'd1 : n_data - 4'd1;
      is_last   = (step_ff == last_step);
      emit      = cmd_valid && (!rsp_valid_ff || rsp_bus.ready);
      cmd_pop   = emit && is_last;
   end

   always_comb begin
      cur_byte = 8'h00;
      hash     = 1'b0;
      if (step_ff == n_data) begin
         cur_byte = crc_ff[15:8];
      end else if (step_ff > n_data) begin
         cur_byte = crc_ff[7:0];
      end else begin
         case (cmd.kind)
            CMD_HEADER: begin
               hash = (step_ff >= 4'd2);
               case (step_ff)
                  4'd0:    cur_byte = cfg.magic_first;
                  4'd1:    cur_byte = cfg.magic_second;
                  4'd2:    cur_byte = cfg.version_byte;
                  4'd3:    cur_byte = cmd.frame_type;
                  4'd4:    cur_byte = cmd.sequence_number[15:8];
                  4'd5:    cur_byte = cmd.sequence_number[7:0];
                  4'd6:    cur_byte = cmd.body_length[15:8];
                  default: cur_byte = cmd.body_length[7:0];
               endcase
            end
            CMD_BODY: begin
               hash     = 1'b1;
               cur_byte = cmd.body_byte;
            end
            default: begin
               cur_byte = 8'h00;
            end
         endcase
      end
   end

   always_comb begin
      step_in      = step_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
         step_in      = is_last ? 4'd0 : step_ff + 4'd1;
         if (cmd.kind == CMD_HEADER && step_ff == 4'd0) begin
            crc_in = CrcInit;
         end else if (hash) begin
            crc_in = crc_feed(crc_ff, cur_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 4'd0;
         crc_ff       <= CrcInit;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff  <= cur_byte;
         run_last_ff  <= is_last;
         frame_end_ff <= is_last && cmd.has_crc;
         status_ff    <= cmd.status;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_byte  = out_byte_ff;
   assign rsp_bus.run_last  = run_last_ff;
   assign rsp_bus.frame_end = frame_end_ff;
   assign rsp_bus.status    = status_ff;

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && frame_end_ff |-> run_last_ff)
      else $error("frame end not on last byte of transaction");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != STATUS_OK |-> run_last_ff && out_byte_ff == 8'h00)
      else $error("error response malformed");

   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      step_ff <= 4'd9)
      else $error("byte step counter out of range");

endmodule

[hw/rtl/crc_framed_packet_encoder_unit.sv]
// CRC framed packet encoder, top level: configuration registers, front end,
// command queue and back end. Depends on cfe_pkg, cfe_req_if, cfe_rsp_if,
// cfe_front, cfe_queue and cfe_back.
//
// Usage:
//   req_bus carries one transaction per frame start (func 0: type, sequence,
//   length) or per payload byte (func 1). rsp_bus returns a byte run per
//   transaction: 8 header bytes for a start, 1 byte per payload item, plus two
//   CRC-16/CCITT-FALSE bytes after the last payload byte (or after the header
//   for an empty body). Malformed requests give one zero byte with a status.
//   csr_* writes magic_first (0), magic_second (1) and version_byte (2); write
//   only while the block is idle.
//   An accepted request goes through the command queue, and its first byte
//   then into the response register. The single back-end byte sequencer sends
//   one response byte per cycle while rsp_bus.ready holds; a payload request
//   gives 1 (or 3) output bytes, a header 8 (or 10), and the command queue
//   (QUEUE_DEPTH entries) absorbs requests meanwhile.
//   Reset clears frame state, queue and config; the CRC is set to CrcInit.
//   While rsp_bus.ready is low a valid response byte holds, the back end
//   stops and req_bus.ready drops once the queue fills.
`timescale 1ns / 1ps

module crc_framed_packet_encoder_unit #(
   parameter int unsigned QUEUE_DEPTH = cfe_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   cfe_req_if.sink    req_bus,
   cfe_rsp_if.source  rsp_bus,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wr_data
);
   import cfe_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    cmd_push;
   cmd_type cmd_in_data;
   logic    queue_full;
   logic    cmd_pop;
   logic    head_valid;
   cmd_type head_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MAGIC_FIRST:  cfg_in.magic_first  = csr_wr_data;
            CSR_MAGIC_SECOND: cfg_in.magic_second = csr_wr_data;
            CSR_VERSION:      cfg_in.version_byte = csr_wr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_in_data)
   );

   cfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_in_data),
      .full       (queue_full),
      .pop        (cmd_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   cfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (head_valid),
      .cmd       (head_data),
      .cmd_pop   (cmd_pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

[tb/tb.sv]
// Self-checking testbench for crc_framed_packet_encoder_unit: transactions from a
// queue, a clocked driver and monitor, and a byte-level frame/CRC predictor.
// Depends on cfe_pkg, cfe_req_if, cfe_rsp_if and the encoder RTL.
`timescale 1ns / 1ps

module tb;
   import cfe_pkg::*;

   localparam int unsigned WatchdogLimit = 2000;
   localparam logic        FuncStart     = 1'b0;
   localparam logic        FuncBody      = 1'b1;

   typedef struct packed {
      logic        func;
      logic [7:0]  frame_type;
      logic [15:0] sequence_number;
      logic [15:0] body_length;
      logic [7:0]  body_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
      status_type status;
   } wire_byte_type;

   logic          clock;
   logic          reset;
   logic          csr_wr_en;
   csr_index_type csr_index;
   logic [7:0]    csr_wr_data;

   cfe_req_if req_bus ();
   cfe_rsp_if rsp_bus ();

   crc_framed_packet_encoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   req_item_type  pending_reqs[$];
   wire_byte_type frame_bytes_due[$];

   int          send_idle_pct;
   int          recv_stall_pct;
   int          errors;
   int unsigned idle_cycles;
   logic        req_hold;

   // encoder model state
   cfg_type     enc_cfg;
   logic [15:0] enc_crc;
   logic [15:0] enc_left;
   logic        enc_open;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ data[i];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CrcPoly;
         end
      end
      return c;
   endfunction

   task automatic emit(input logic [7:0] b, input logic fend, input status_type st);
      wire_byte_type w;
      w.out_byte  = b;
      w.run_last  = 1'b0;
      w.frame_end = fend;
      w.status    = st;
      frame_bytes_due.push_back(w);
   endtask

   task automatic emit_hashed(input logic [7:0] b);
      enc_crc = crc_next(enc_crc, b);
      emit(b, 1'b0, STATUS_OK);
   endtask

   task automatic emit_crc();
      emit(enc_crc[15:8], 1'b0, STATUS_OK);
      emit(enc_crc[7:0], 1'b1, STATUS_OK);
      enc_crc  = CrcInit;
      enc_left = '0;
      enc_open = 1'b0;
   endtask

   task automatic predict_wire_bytes(input req_item_type it);
      wire_byte_type last;
      if (it.func == FuncStart) begin
         if (enc_open) begin
            emit(8'h00, 1'b0, STATUS_IN_FRAME);
         end else if (it.body_length > MaxBody) begin
            emit(8'h00, 1'b0, STATUS_TOO_LONG);
         end else begin
            enc_crc = CrcInit;
            emit(enc_cfg.magic_first, 1'b0, STATUS_OK);
            emit(enc_cfg.magic_second, 1'b0, STATUS_OK);
            emit_hashed(enc_cfg.version_byte);
            emit_hashed(it.frame_type);
            emit_hashed(it.sequence_number[15:8]);
            emit_hashed(it.sequence_number[7:0]);
            emit_hashed(it.body_length[15:8]);
            emit_hashed(it.body_length[7:0]);
            if (it.body_length == 16'd0) begin
               emit_crc();
            end else begin
               enc_left = it.body_length;
               enc_open = 1'b1;
            end
         end
      end else begin
         if (!enc_open) begin
            emit(8'h00, 1'b0, STATUS_NO_FRAME);
         end else begin
            emit_hashed(it.body_byte);
            enc_left = enc_left - 16'd1;
            if (enc_left == 16'd0) begin
               emit_crc();
            end
         end
      end
      last = frame_bytes_due.pop_back();
      last.run_last = 1'b1;
      frame_bytes_due.push_back(last);
   endtask

   function automatic req_item_type start_item(input logic [7:0] ftype, input logic [15:0] seq,
                                               input logic [15:0] len);
      req_item_type it;
      it.func            = FuncStart;
      it.frame_type      = ftype;
      it.sequence_number = seq;
      it.body_length     = len;
      it.body_byte       = 8'($urandom);
      return it;
   endfunction

   function automatic req_item_type body_item(input logic [7:0] b);
      req_item_type it;
      it.func            = FuncBody;
      it.frame_type      = 8'($urandom);
      it.sequence_number = 16'($urandom);
      it.body_length     = 16'($urandom);
      it.body_byte       = b;
      return it;
   endfunction

   task automatic queue_random_frame(input logic [15:0] len, input int noise_pct);
      pending_reqs.push_back(start_item(8'($urandom), 16'($urandom), len));
      for (int i = 0; i < int'(len); i++) begin
         if ($urandom_range(99) < noise_pct) begin
            pending_reqs.push_back(start_item(8'($urandom), 16'($urandom), 16'($urandom)));
         end
         pending_reqs.push_back(body_item(8'($urandom)));
      end
   endtask

   task automatic queue_random_phase(input int n);
      int r;
      int base;
      base = pending_reqs.size();
      while (pending_reqs.size() - base < n) begin
         r = $urandom_range(99);
         if (r < 72) begin
            queue_random_frame(16'($urandom_range(8, 0)), 8);
         end else if (r < 82) begin
            pending_reqs.push_back(body_item(8'($urandom)));
         end else if (r < 92) begin
            pending_reqs.push_back(start_item(8'($urandom), 16'($urandom),
               16'($urandom_range(32'hFFFF, 32'(MaxBody) + 32'd1))));
         end else begin
            queue_random_frame(16'($urandom_range(40, 9)), 15);
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_bus.valid || frame_bytes_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_settings(input cfg_type s);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_MAGIC_FIRST;
      csr_wr_data <= s.magic_first;
      @(negedge clock);
      csr_index   <= CSR_MAGIC_SECOND;
      csr_wr_data <= s.magic_second;
      @(negedge clock);
      csr_index   <= CSR_VERSION;
      csr_wr_data <= s.version_byte;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      enc_cfg = s;
   endtask

   task automatic run_phase(input int send_pct, input int stall_pct, input int n);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      queue_random_phase(n);
      wait_idle();
   endtask

   // driver: request payload and response back-pressure change on the falling edge
   always @(negedge clock) begin
      req_item_type nxt;
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!req_hold) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_reqs[0];
            req_bus.valid           <= 1'b1;
            req_bus.func            <= nxt.func;
            req_bus.frame_type      <= nxt.frame_type;
            req_bus.sequence_number <= nxt.sequence_number;
            req_bus.body_length     <= nxt.body_length;
            req_bus.body_byte       <= nxt.body_byte;
            req_hold = 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor, predictor and watchdog on the rising edge
   always @(posedge clock) begin
      req_item_type  it;
      wire_byte_type w;
      logic          rsp_fire;
      logic          req_fire;
      if (!reset) begin
         rsp_fire = rsp_bus.valid && rsp_bus.ready;
         req_fire = req_bus.valid && req_bus.ready;
         if (rsp_fire) begin
            if (frame_bytes_due.size() == 0) begin
               $error("unexpected transaction: out_byte %0h status %0d",
                      rsp_bus.out_byte, rsp_bus.status);
               errors++;
            end else begin
               w = frame_bytes_due.pop_front();
               if (rsp_bus.out_byte !== w.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", w.out_byte, rsp_bus.out_byte);
                  errors++;
               end
               if (rsp_bus.run_last !== w.run_last) begin
                  $error("run_last: expected %0d, got %0d", w.run_last, rsp_bus.run_last);
                  errors++;
               end
               if (rsp_bus.frame_end !== w.frame_end) begin
                  $error("frame_end: expected %0d, got %0d", w.frame_end, rsp_bus.frame_end);
                  errors++;
               end
               if (rsp_bus.status !== w.status) begin
                  $error("status: expected %0d, got %0d", w.status, rsp_bus.status);
                  errors++;
               end
            end
         end
         if (req_fire) begin
            it.func            = req_bus.func;
            it.frame_type      = req_bus.frame_type;
            it.sequence_number = req_bus.sequence_number;
            it.body_length     = req_bus.body_length;
            it.body_byte       = req_bus.body_byte;
            predict_wire_bytes(it);
            pending_reqs.delete(0);
            req_hold = 1'b0;
         end
         if (req_fire || rsp_fire || csr_wr_en) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WatchdogLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      cfg_type s;
      reset                   = 1'b1;
      csr_wr_en               = 1'b0;
      csr_index               = CSR_MAGIC_FIRST;
      csr_wr_data             = 8'h00;
      req_bus.valid           = 1'b0;
      req_bus.func            = FuncStart;
      req_bus.frame_type      = 8'h00;
      req_bus.sequence_number = 16'h0000;
      req_bus.body_length     = 16'h0000;
      req_bus.body_byte       = 8'h00;
      rsp_bus.ready           = 1'b0;
      send_idle_pct           = 0;
      recv_stall_pct          = 0;
      errors                  = 0;
      idle_cycles             = 0;
      req_hold                = 1'b0;
      enc_cfg                 = '0;
      enc_crc                 = CrcInit;
      enc_left                = '0;
      enc_open                = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: error cases, empty body, boundaries, start inside an open frame
      pending_reqs.push_back(body_item(8'hFF));
      pending_reqs.push_back(start_item(8'hFF, 16'hFFFF, 16'd0));
      pending_reqs.push_back(start_item(8'h00, 16'h0000, MaxBody + 16'd1));
      pending_reqs.push_back(start_item(8'hFF, 16'hFFFF, 16'hFFFF));
      pending_reqs.push_back(start_item(8'h00, 16'h0000, 16'd1));
      pending_reqs.push_back(body_item(8'h00));
      pending_reqs.push_back(start_item(8'h5A, 16'h1234, 16'd3));
      pending_reqs.push_back(start_item(8'hFF, 16'hFFFF, 16'hFFFF));
      pending_reqs.push_back(body_item(8'hFF));
      pending_reqs.push_back(start_item(8'h00, 16'h0000, 16'd0));
      pending_reqs.push_back(body_item(8'h00));
      pending_reqs.push_back(body_item(8'hA5));
      pending_reqs.push_back(body_item(8'h00));
      pending_reqs.push_back(start_item(8'h80, 16'h8001, 16'd2));
      pending_reqs.push_back(body_item(8'h7F));
      pending_reqs.push_back(body_item(8'h80));
      pending_reqs.push_back(start_item(8'h00, 16'h0000, 16'd0));
      wait_idle();

      s = {8'hFF, 8'h00, 8'hFF};
      write_settings(s);
      run_phase(0, 0, 35);

      s = {8'h00, 8'hFF, 8'h00};
      write_settings(s);
      run_phase(49, 0, 35);

      s.magic_first  = 8'($urandom);
      s.magic_second = 8'($urandom);
      s.version_byte = 8'($urandom);
      write_settings(s);
      queue_random_frame(MaxBody, 2);
      run_phase(0, 49, 35);

      s = {8'hFF, 8'hFF, 8'hFF};
      write_settings(s);
      run_phase(14, 14, 35);

      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
